// ===== hw/rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, codes and sizes for the ARP cache and responder.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  localparam int CACHE_ENTRIES   = 16;
  localparam int PENDING_ENTRIES = 8;
  localparam int SCAN_N = (CACHE_ENTRIES > PENDING_ENTRIES) ? CACHE_ENTRIES : PENDING_ENTRIES;
  localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int SW = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ARP  = 2'd1;
  localparam logic [1:0] CMD_IP   = 2'd2;

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic [2:0] ACT_REPLY   = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_FRAME   = 3'd2;
  localparam logic [2:0] ACT_DROP    = 3'd3;
  localparam logic [2:0] ACT_REQUEST = 3'd4;

  localparam logic [1:0] REG_MY_IP  = 2'd0;
  localparam logic [1:0] REG_MY_MAC = 2'd1;
  localparam logic [1:0] REG_EXPIRY = 2'd2;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] BCAST_IP  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [31:0] packet_src_ip;
    logic [31:0] packet_dst_ip;
    logic [31:0] next_hop_ip;
  } arpc_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] dest_mac;
    logic [31:0] dest_ip;
  } arpc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } arpc_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } arpc_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       scan_last;
    logic       out_free;
  } arpc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences load, then table scan and decision for ARP and IP input words.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl
  import arpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire arpc_stat_t stat,
  output arpc_cmd_t       cmd
);

  arpc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (stat.command == CMD_ARP || stat.command == CMD_IP)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SCAN:   cmd.scan = 1'b1;
      ST_DECIDE: cmd.commit = stat.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/arpc_datapath.sv =====
// ----------------------------------------------------------------------------
// ARP cache datapath
// Holds the tables, configuration, seconds counter, scan trackers and output.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_datapath
  import arpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire arpc_in_t    in_word,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire arpc_cmd_t   cmd,
  output arpc_stat_t       stat,
  output logic             out_valid,
  input  wire logic        out_stall,
  output arpc_out_t        out_word
);

  logic [31:0] my_ip;
  logic [47:0] my_mac;
  logic [15:0] expiry_time;
  logic [31:0] now_seconds;

  logic [31:0] entry_ip    [CACHE_ENTRIES];
  logic [47:0] entry_mac   [CACHE_ENTRIES];
  logic [31:0] entry_stamp [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0]   entry_used;
  logic [31:0] pending_ip  [PENDING_ENTRIES];
  logic [PENDING_ENTRIES-1:0] pending_used;

  arpc_in_t item;
  logic [SW-1:0] idx;

  logic          c_hit, c_free_found;
  logic [CW-1:0] c_slot, c_free, c_old;
  logic [47:0]   c_mac;
  logic [31:0]   c_stamp, c_old_stamp;
  logic          p_hit, p_free_found;
  logic [PW-1:0] p_slot, p_free;

  logic [31:0]   key;
  logic [CW-1:0] ci;
  logic [PW-1:0] pi;
  logic          c_in, p_in;

  logic          emit;
  arpc_out_t     res;
  logic [CW-1:0] learn_slot;
  logic          pend_add, pend_clear;
  logic [32:0]   limit;

  assign key  = (item.command == CMD_ARP) ? item.sender_ip : item.next_hop_ip;
  assign ci   = idx[CW-1:0];
  assign pi   = idx[PW-1:0];
  assign c_in = ({1'b0, idx} < (SW+1)'(CACHE_ENTRIES));
  assign p_in = ({1'b0, idx} < (SW+1)'(PENDING_ENTRIES));

  assign stat.command   = cmd.load ? in_word.command : item.command;
  assign stat.scan_last = (idx == SW'(SCAN_N - 1));
  assign stat.out_free  = !out_valid || !out_stall;

  assign learn_slot = c_hit ? c_slot : (c_free_found ? c_free : c_old);
  assign limit = {1'b0, c_stamp} + {17'd0, expiry_time};

  // Decision made once the scan of both tables is complete.
  always_comb begin
    emit       = 1'b0;
    pend_add   = 1'b0;
    pend_clear = 1'b0;
    res.action   = ACT_DROP;
    res.dest_mac = 48'd0;
    res.dest_ip  = item.next_hop_ip;
    if (item.command == CMD_ARP) begin
      res.dest_ip = item.sender_ip;
      if (item.arp_opcode == OP_REQUEST) begin
        emit = (item.target_ip == my_ip);
        res.action   = ACT_REPLY;
        res.dest_mac = item.sender_mac;
      end else if (item.arp_opcode == OP_REPLY) begin
        emit       = p_hit;
        pend_clear = p_hit;
        res.action   = ACT_RELEASE;
        res.dest_mac = c_hit ? c_mac : item.sender_mac;
      end
    end else begin
      emit = 1'b1;
      if (item.packet_dst_ip == BCAST_IP) begin
        if (item.packet_src_ip == my_ip || item.packet_src_ip == 32'd0) begin
          res.action   = ACT_FRAME;
          res.dest_mac = BCAST_MAC;
        end
      end else if (item.packet_src_ip != my_ip) begin
        res.action = ACT_DROP;
      end else if (c_hit && (limit > {1'b0, now_seconds})) begin
        res.action   = ACT_FRAME;
        res.dest_mac = c_mac;
      end else if (p_hit || p_free_found) begin
        pend_add     = !p_hit;
        res.action   = ACT_REQUEST;
        res.dest_mac = BCAST_MAC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      my_ip        <= 32'd0;
      my_mac       <= 48'd0;
      expiry_time  <= 16'd60;
      now_seconds  <= 32'd0;
      entry_used   <= '0;
      pending_used <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MY_IP:  my_ip <= cfg_data[31:0];
          REG_MY_MAC: my_mac <= cfg_data;
          REG_EXPIRY: expiry_time <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load && in_word.command == CMD_TICK && now_seconds != 32'hFFFF_FFFF) begin
        now_seconds <= now_seconds + 32'd1;
      end
      // A new result may replace one that leaves in the same cycle.
      if (cmd.commit && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (item.command == CMD_ARP) begin
          entry_used[learn_slot] <= 1'b1;
        end
        if (pend_clear) begin
          pending_used[p_slot] <= 1'b0;
        end
        if (pend_add) begin
          pending_used[p_free] <= 1'b1;
        end
      end
    end
  end

  // Payload, tables and scan trackers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item         <= in_word;
      idx          <= '0;
      c_hit        <= 1'b0;
      c_free_found <= 1'b0;
      p_hit        <= 1'b0;
      p_free_found <= 1'b0;
    end
    if (cmd.scan) begin
      if (!stat.scan_last) begin
        idx <= idx + SW'(1);
      end
      if (c_in) begin
        if (entry_used[ci] && entry_ip[ci] == key && !c_hit) begin
          c_hit   <= 1'b1;
          c_slot  <= ci;
          c_mac   <= entry_mac[ci];
          c_stamp <= entry_stamp[ci];
        end
        if (!entry_used[ci] && !c_free_found) begin
          c_free_found <= 1'b1;
          c_free       <= ci;
        end
        if (entry_used[ci] && (idx == '0 || entry_stamp[ci] < c_old_stamp)) begin
          c_old       <= ci;
          c_old_stamp <= entry_stamp[ci];
        end
      end
      if (p_in) begin
        if (pending_used[pi] && pending_ip[pi] == key && !p_hit) begin
          p_hit  <= 1'b1;
          p_slot <= pi;
        end
        if (!pending_used[pi] && !p_free_found) begin
          p_free_found <= 1'b1;
          p_free       <= pi;
        end
      end
    end
    if (cmd.commit) begin
      if (item.command == CMD_ARP) begin
        entry_stamp[learn_slot] <= now_seconds;
        if (!c_hit) begin
          entry_ip[learn_slot]  <= item.sender_ip;
          entry_mac[learn_slot] <= item.sender_mac;
        end
      end
      if (pend_add) begin
        pending_ip[p_free] <= item.next_hop_ip;
      end
      if (emit) begin
        out_word <= res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/arp_cache_and_responder_unit.sv =====
// ----------------------------------------------------------------------------
// ARP cache and responder
// Caches IP-to-MAC bindings, answers ARP and resolves outbound next hops.
// ----------------------------------------------------------------------------
// Usage: input words arrive on in_valid / in_stall / in_word; a word is taken
// at a clock edge where in_valid is high and in_stall is low. Results leave
// on out_valid / out_stall / out_word, at most one per input word.
// Tick words (and unknown commands) are taken without a scan and give no result.
// ARP and outbound IP words scan the cache and the pending table in parallel,
// one entry per cycle, over all 16 entries (the larger table sets this), then
// reach a decision state that writes the result, if any, to the output
// register; no new word is taken until that decision is made.
// The result sits in an output register; while the receiver stalls it holds,
// and a following word is scanned but waits in its decision cycle until the
// output register is free. Configuration writes (cfg_write, cfg_index,
// cfg_data) take effect at once and belong in idle time.
// Synchronous reset empties both tables, zeroes the seconds counter and the
// addresses, and sets the expiry time to 60 seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_and_responder_unit
  import arpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire arpc_in_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output arpc_out_t        out_word,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  // Commands flow from controller to datapath, status flows back.
  arpc_cmd_t  cmd;
  arpc_stat_t stat;

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  arpc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// ARP cache and responder testbench
// Drives ARP, outbound IP and tick words with random idling and a long output
// hold-off, predicts each result in a local model and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import arpc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  arpc_in_t    in_word;
  logic        out_valid;
  logic        out_stall;
  arpc_out_t   out_word;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;

  arp_cache_and_responder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Local copy of the block's state and registers.
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] expiry;
  logic [31:0] c_ip [CACHE_ENTRIES];
  logic [47:0] c_mac [CACHE_ENTRIES];
  logic [31:0] c_stamp [CACHE_ENTRIES];
  logic        c_used [CACHE_ENTRIES];
  logic [31:0] p_ip [PENDING_ENTRIES];
  logic        p_used [PENDING_ENTRIES];
  logic [31:0] seconds;

  arpc_out_t   expected_actions[$];
  int          errors = 0;
  bit          quiet = 0;      // when set, neither sender nor receiver idles at random
  bit          holdoff = 0;    // long receiver stall in progress
  logic [31:0] hop_pool [8];   // small address pool so lookups hit

  function automatic int cache_lookup(logic [31:0] ip);
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (c_used[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int pending_lookup(logic [31:0] ip);
    for (int i = 0; i < PENDING_ENTRIES; i++)
      if (p_used[i] && p_ip[i] == ip) return i;
    return -1;
  endfunction

  task automatic learn_sender(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = cache_lookup(ip);
    if (slot >= 0) begin
      c_stamp[slot] = seconds;
      return;
    end
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (!c_used[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) begin
      // Full table: evict the oldest stamp, lowest index on a tie.
      slot = 0;
      for (int i = 1; i < CACHE_ENTRIES; i++)
        if (c_stamp[i] < c_stamp[slot]) slot = i;
    end
    c_used[slot] = 1'b1;
    c_ip[slot] = ip;
    c_mac[slot] = mac;
    c_stamp[slot] = seconds;
  endtask

  // Applies one word to the local state; returns 1 with the action it causes.
  task automatic resolve_word(input arpc_in_t w, output bit has, output arpc_out_t r);
    int slot;
    has = 0;
    r = '0;
    case (w.command)
      CMD_TICK: begin
        if (seconds != 32'hFFFF_FFFF) seconds++;
      end
      CMD_ARP: begin
        learn_sender(w.sender_ip, w.sender_mac);
        if (w.arp_opcode == OP_REQUEST) begin
          if (w.target_ip == own_ip) begin
            has = 1;
            r = '{ACT_REPLY, w.sender_mac, w.sender_ip};
          end
        end else if (w.arp_opcode == OP_REPLY) begin
          slot = pending_lookup(w.sender_ip);
          if (slot >= 0) begin
            p_used[slot] = 1'b0;
            slot = cache_lookup(w.sender_ip);
            has = 1;
            r = '{ACT_RELEASE, (slot >= 0) ? c_mac[slot] : w.sender_mac, w.sender_ip};
          end
        end
      end
      CMD_IP: begin
        has = 1;
        if (w.packet_dst_ip == BCAST_IP) begin
          if (w.packet_src_ip != own_ip && w.packet_src_ip != 0)
            r = '{ACT_DROP, 48'd0, w.next_hop_ip};
          else
            r = '{ACT_FRAME, BCAST_MAC, w.next_hop_ip};
        end else if (w.packet_src_ip != own_ip) begin
          r = '{ACT_DROP, 48'd0, w.next_hop_ip};
        end else begin
          slot = cache_lookup(w.next_hop_ip);
          if (slot >= 0 && ({1'b0, c_stamp[slot]} + 33'(expiry)) > {1'b0, seconds}) begin
            r = '{ACT_FRAME, c_mac[slot], w.next_hop_ip};
          end else begin
            r = '{ACT_REQUEST, BCAST_MAC, w.next_hop_ip};
            if (pending_lookup(w.next_hop_ip) < 0) begin
              slot = -1;
              for (int i = 0; i < PENDING_ENTRIES; i++)
                if (!p_used[i]) begin
                  slot = i;
                  break;
                end
              if (slot < 0) r = '{ACT_DROP, 48'd0, w.next_hop_ip};
              else begin
                p_used[slot] = 1'b1;
                p_ip[slot] = w.next_hop_ip;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offers one word, waits for its acceptance, queues the predicted result.
  // A typed-in expectation, when given, is checked against the prediction.
  // Valid is dropped by the next offer's idling or by the caller.
  task automatic offer_word(arpc_in_t w, bit typed = 0, arpc_out_t want = '0);
    bit has;
    arpc_out_t r;
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    resolve_word(w, has, r);
    if (typed && (!has || r !== want)) begin
      $display("%0t table row mismatch: expected %h actual %h", $time, want, r);
      errors++;
    end
    if (has) expected_actions.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain_and_set(logic [1:0] idx, logic [47:0] val);
    in_valid <= 1'b0;
    while (expected_actions.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MY_IP:  own_ip = val[31:0];
      REG_MY_MAC: own_mac = val;
      default:    expiry = val[15:0];
    endcase
  endtask

  function automatic arpc_in_t random_fill();
    logic [255:0] b;
    b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return b[$bits(arpc_in_t)-1:0];
  endfunction

  function automatic arpc_in_t arp_word(logic [15:0] op, logic [31:0] sip, logic [47:0] smac,
                                        logic [31:0] tip);
    arpc_in_t w;
    w = random_fill();
    w.command = CMD_ARP;
    w.arp_opcode = op;
    w.sender_ip = sip;
    w.sender_mac = smac;
    w.target_ip = tip;
    return w;
  endfunction

  function automatic arpc_in_t ip_word(logic [31:0] src, logic [31:0] dst, logic [31:0] hop);
    arpc_in_t w;
    w = random_fill();
    w.command = CMD_IP;
    w.packet_src_ip = src;
    w.packet_dst_ip = dst;
    w.next_hop_ip = hop;
    return w;
  endfunction

  function automatic arpc_in_t random_word();
    arpc_in_t w;
    int pick;
    logic [31:0] a;
    a = ($urandom_range(9) == 0) ? $urandom : hop_pool[$urandom_range(7)];
    pick = $urandom_range(99);
    if (pick < 15) begin
      w = arp_word(16'd0, 0, 0, 0);
      w.command = ($urandom_range(9) == 0) ? 2'd3 : CMD_TICK;
      if ($urandom_range(1)) w = random_fill();
      if (w.command inside {CMD_ARP, CMD_IP}) w.command = CMD_TICK;
    end else if (pick < 45) begin
      w = arp_word($urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2)), a,
                   {$urandom, $urandom}, $urandom_range(1) ? own_ip : $urandom);
    end else begin
      w = ip_word($urandom_range(5) == 0 ? $urandom : ($urandom_range(7) == 0 ? 0 : own_ip),
                  $urandom_range(4) == 0 ? BCAST_IP : $urandom, a);
    end
    return w;
  endfunction

  // Result checker and receiver idling.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_actions.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_word);
        errors++;
      end else begin
        if (out_word.action !== expected_actions[0].action) begin
          $display("%0t action: expected %0d actual %0d", $time,
                   expected_actions[0].action, out_word.action);
          errors++;
        end
        if (out_word.dest_mac !== expected_actions[0].dest_mac) begin
          $display("%0t dest_mac: expected %h actual %h", $time,
                   expected_actions[0].dest_mac, out_word.dest_mac);
          errors++;
        end
        if (out_word.dest_ip !== expected_actions[0].dest_ip) begin
          $display("%0t dest_ip: expected %h actual %h", $time,
                   expected_actions[0].dest_ip, out_word.dest_ip);
          errors++;
        end
        void'(expected_actions.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= holdoff || (!quiet && $urandom_range(99) < 21);
  end

  // Long receiver hold-off counted here, while the sender keeps offering.
  initial begin
    wait (!rst);
    repeat (3000) @(negedge clk);
    holdoff = 1'b1;
    repeat (400) @(negedge clk);
    holdoff = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  typedef struct {
    arpc_in_t  w;
    bit        typed;
    arpc_out_t want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    logic [47:0] m;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_MY_IP;
    cfg_data = '0;
    own_ip = 0;
    own_mac = 0;
    expiry = 16'd60;
    seconds = 0;
    for (int i = 0; i < CACHE_ENTRIES; i++) c_used[i] = 1'b0;
    for (int i = 0; i < PENDING_ENTRIES; i++) p_used[i] = 1'b0;
    for (int i = 0; i < 8; i++) hop_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset my_ip is zero: a request for 0.0.0.0 gets a reply.
    rows.push_back('{arp_word(OP_REQUEST, 32'hFFFF_FFFF, BCAST_MAC, 0), 1,
                     '{ACT_REPLY, BCAST_MAC, 32'hFFFF_FFFF}});
    rows.push_back('{ip_word(32'h0, BCAST_IP, 32'h0), 1, '{ACT_FRAME, BCAST_MAC, 32'h0}});
    rows.push_back('{ip_word(32'h1, BCAST_IP, 32'hFFFF_FFFF), 1,
                     '{ACT_DROP, 48'd0, 32'hFFFF_FFFF}});
    rows.push_back('{ip_word(32'h5, 32'h1, 32'h7), 1, '{ACT_DROP, 48'd0, 32'h7}});
    foreach (rows[i]) offer_word(rows[i].w, rows[i].typed, rows[i].want);
    rows.delete();

    drain_and_set(REG_MY_IP, 48'hFFFF_FFFF);
    drain_and_set(REG_MY_MAC, 48'hFFFF_FFFF_FFFF);
    drain_and_set(REG_EXPIRY, 48'd0);
    // Zero expiry: cached entries are never valid, so requests go out.
    offer_word(arp_word(OP_REQUEST, 32'h0A00_0001, 48'h0, 32'h1));
    offer_word(ip_word(32'hFFFF_FFFF, 32'h1, 32'h0A00_0001), 1,
               '{ACT_REQUEST, BCAST_MAC, 32'h0A00_0001});
    offer_word(ip_word(32'hFFFF_FFFF, 32'h1, 32'h0A00_0001));  // already pending
    offer_word(arp_word(OP_REPLY, 32'h0A00_0001, 48'h1234, 32'h0));  // known sender: mac kept
    offer_word(arp_word(16'hFFFF, 32'h0A00_0002, 48'h1, 32'h0));     // other opcode
    offer_word(arp_word(OP_REPLY, 32'h0A00_0003, 48'h1, 32'h0));     // no pending
    // Fill the pending table, then one more resolve is dropped.
    for (int i = 0; i < PENDING_ENTRIES + 1; i++)
      offer_word(ip_word(32'hFFFF_FFFF, 32'h1, 32'h0B00_0000 + i));
    drain_and_set(REG_EXPIRY, 48'hFFFF);
    // Overfill the cache so the oldest entry is replaced.
    for (int i = 0; i < CACHE_ENTRIES + 2; i++) begin
      offer_word(arp_word(OP_REQUEST, 32'h0C00_0000 + i, {16'h0, 32'h0C00_0000 + i}, 0));
      if (i % 4 == 0) offer_word(ip_word(0, 0, 0) ^ '0 | arpc_in_t'(0));
    end
    offer_word(ip_word(32'hFFFF_FFFF, 32'h1, 32'h0C00_0005));

    drain_and_set(REG_MY_IP, 48'($urandom));
    drain_and_set(REG_EXPIRY, 48'd3);
    for (int k = 0; k < 1750; k++) begin
      if (k == 600) begin
        m = {$urandom, $urandom};
        drain_and_set(REG_MY_MAC, m);
        drain_and_set(REG_EXPIRY, 48'd20);
        drain_and_set(REG_MY_IP, 48'(hop_pool[0]));
      end
      if (k == 1200) begin
        drain_and_set(REG_EXPIRY, 48'd1);
        drain_and_set(REG_MY_IP, 48'd0);
      end
      quiet = (k >= 1400 && k < 1550);
      offer_word(random_word());
    end
    quiet = 0;
    in_valid <= 1'b0;

    while (expected_actions.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
